@@ rtl/core/isfrm_pkg.sv @@
package isfrm_pkg;

   localparam int STATE_COUNT  = 12;
   localparam int ACTION_COUNT = 4;
   localparam int MEASURED     = 8;
   localparam int GAIN_WORDS   = STATE_COUNT * ACTION_COUNT;
   localparam int STORE_DEPTH  = GAIN_WORDS + 5;
   localparam int HOVER_INDEX  = GAIN_WORDS + 4;
   localparam int COEF_W       = 48;

   // config register indexes
   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_ALT    = 3'd1;
   localparam logic [2:0] REG_ROLL   = 3'd2;
   localparam logic [2:0] REG_PITCH  = 3'd3;
   localparam logic [2:0] REG_YAW    = 3'd4;
   localparam logic [2:0] REG_PERIOD = 3'd5;

   // bit j set: mix term j+1 (roll, pitch, yaw) is subtracted for that rotor
   localparam logic [2:0] ROTOR_NEG [4] = '{3'b011, 3'b000, 3'b110, 3'b101};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INTEG,
      ST_FETCH,
      ST_LOAD,
      ST_MUL,
      ST_SCALE,
      ST_ACCUM,
      ST_HOVER,
      ST_RINIT,
      ST_RADD,
      ST_RCLAMP,
      ST_SQRT,
      ST_OUT
   } state_type;

endpackage

@@ rtl/core/isfrm_ram.sv @@
module isfrm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 53
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/core/integral_state_feedback_rotor_mixer.sv @@
// Sequence: a load beat is written in the cycle it is accepted; a sample runs the four
// integrators (multiply, then saturating add), then 52 products (fetch, operand load,
// 4 partial 24x24 products, scale, accumulate), the hover offset, then per rotor a mix
// sum, a clamp and a 32-step bit-serial square root.
// Throughput: one load per cycle while idle; one sample at a time, the next waits for idle.
// Reset: synchronous; coefficients read as zero until loaded, integrators zero, period 655.
module integral_state_feedback_rotor_mixer
   import isfrm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [5:0]          req_coef_index,
   input  logic signed [47:0]  req_coef_value,
   input  logic signed [31:0]  req_height,
   input  logic signed [31:0]  req_vertical_rate,
   input  logic signed [31:0]  req_roll_angle,
   input  logic signed [31:0]  req_roll_rate,
   input  logic signed [31:0]  req_pitch_angle,
   input  logic signed [31:0]  req_pitch_rate,
   input  logic signed [31:0]  req_yaw_angle,
   input  logic signed [31:0]  req_yaw_rate,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_thrust_command,
   output logic signed [31:0]  rsp_roll_command,
   output logic signed [31:0]  rsp_pitch_command,
   output logic signed [31:0]  rsp_yaw_command,
   output logic [31:0]         rsp_rotor_speed_a,
   output logic [31:0]         rsp_rotor_speed_b,
   output logic [31:0]         rsp_rotor_speed_c,
   output logic [31:0]         rsp_rotor_speed_d,
   // config port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int AW = $clog2(STORE_DEPTH);

   // ---------------- config registers ----------------
   logic               enable_ff;
   logic signed [31:0] ref_ff [4];
   logic [15:0]        period_ff;
   logic               cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         for (int i = 0; i < 4; i++) ref_ff[i] <= '0;
         period_ff <= 16'd655;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            REG_ENABLE: enable_ff <= pwdata[0];
            REG_ALT:    ref_ff[0] <= pwdata;
            REG_ROLL:   ref_ff[1] <= pwdata;
            REG_PITCH:  ref_ff[2] <= pwdata;
            REG_YAW:    ref_ff[3] <= pwdata;
            REG_PERIOD: period_ff <= pwdata[15:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_ENABLE: prdata = {31'd0, enable_ff};
         REG_ALT:    prdata = ref_ff[0];
         REG_ROLL:   prdata = ref_ff[1];
         REG_PITCH:  prdata = ref_ff[2];
         REG_YAW:    prdata = ref_ff[3];
         REG_PERIOD: prdata = {16'd0, period_ff};
         default:    prdata = '0;
      endcase
   end

   // ---------------- control ----------------
   state_type state_ff, state_in;
   logic [4:0] cnt_ff;
   logic [5:0] t_ff;         // coefficient word being used
   logic [1:0] row_ff;
   logic [3:0] col_ff;
   logic [1:0] rotor_ff;
   logic       req_fire, load_fire, rsp_free;

   assign req_fire  = req_valid & ~req_stall;
   assign load_fire = req_fire & ~req_action;
   assign rsp_free  = ~rsp_valid | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire && req_action && enable_ff) state_in = ST_INTEG;
         ST_INTEG:  if (cnt_ff == 5'd7) state_in = ST_FETCH;
         ST_FETCH:  state_in = (t_ff == 6'(HOVER_INDEX)) ? ST_HOVER : ST_LOAD;
         ST_LOAD:   state_in = ST_MUL;
         ST_MUL:    if (cnt_ff == 5'd4) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_FETCH;
         ST_HOVER:  state_in = ST_RINIT;
         ST_RINIT:  state_in = ST_RADD;
         ST_RADD:   if (cnt_ff == 5'd2) state_in = ST_RCLAMP;
         ST_RCLAMP: state_in = ST_SQRT;
         ST_SQRT:   if (cnt_ff == 5'd31) state_in = (rotor_ff == 2'd3) ? ST_OUT : ST_RINIT;
         ST_OUT:    if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------- coefficient store ----------------
   logic [STORE_DEPTH-1:0] cvalid_ff;
   logic                   rd_valid_ff;
   logic [COEF_W-1:0]      ram_rdata;
   logic signed [47:0]     coef;
   logic                   load_ok;

   assign load_ok = load_fire && (req_coef_index < 6'(STORE_DEPTH));

   isfrm_ram #(.WIDTH(COEF_W), .DEPTH(STORE_DEPTH)) u_coef_ram (
      .clock (clock),
      .we    (load_ok),
      .waddr (req_coef_index[AW-1:0]),
      .wdata (req_coef_value),
      .raddr (t_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   // never-loaded words read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (load_ok) cvalid_ff[req_coef_index[AW-1:0]] <= 1'b1;
         rd_valid_ff <= (t_ff < 6'(STORE_DEPTH)) ? cvalid_ff[t_ff[AW-1:0]] : 1'b0;
      end
   end

   assign coef = rd_valid_ff ? $signed(ram_rdata) : 48'sd0;

   // ---------------- datapath ----------------
   logic signed [31:0] meas_ff  [MEASURED];
   logic signed [47:0] integ_ff [4];
   logic signed [49:0] iprod_ff;
   logic signed [31:0] act_ff   [4];
   logic signed [63:0] mixt_ff  [4];
   logic [31:0]        speed_ff [4];
   logic [47:0]        ma_ff, mb_ff;
   logic               neg_ff, wide_ff;
   logic [47:0]        pp_ff;
   logic [1:0]         psh_ff;
   logic [95:0]        prod_ff;
   logic signed [63:0] term_ff, acc_ff, m_ff;
   logic [63:0]        x_ff, res_ff, bit_ff;

   // integrator step
   logic [1:0]         ii;
   logic signed [32:0] ierr;
   logic signed [49:0] iprod, isum;
   assign ii    = cnt_ff[2:1];
   assign ierr  = {ref_ff[ii][31], ref_ff[ii]} - {meas_ff[{ii, 1'b0}][31], meas_ff[{ii, 1'b0}]};
   assign iprod = ierr * $signed({1'b0, period_ff});
   assign isum  = {{2{integ_ff[ii][47]}}, integ_ff[ii]} + iprod_ff;

   // operand select
   logic signed [47:0] opb;
   always_comb begin
      if (t_ff < 6'(GAIN_WORDS)) begin
         if (col_ff < 4'd8) opb = 48'(meas_ff[col_ff[2:0]]);
         else               opb = integ_ff[col_ff[1:0]];
      end else begin
         opb = 48'(act_ff[t_ff[1:0]]);
      end
   end

   logic [23:0] ahalf, bhalf;
   assign ahalf = cnt_ff[1] ? ma_ff[47:24] : ma_ff[23:0];
   assign bhalf = cnt_ff[0] ? mb_ff[47:24] : mb_ff[23:0];

   logic [95:0] pp_sh;
   always_comb begin
      case (psh_ff)
         2'd0:    pp_sh = {48'd0, pp_ff};
         2'd1:    pp_sh = {24'd0, pp_ff, 24'd0};
         default: pp_sh = {pp_ff, 48'd0};
      endcase
   end

   // signed floor shift of the product
   logic signed [96:0] sprod, sshift;
   assign sprod  = neg_ff ? -$signed({1'b0, prod_ff}) : $signed({1'b0, prod_ff});
   assign sshift = wide_ff ? (sprod >>> 40) : (sprod >>> 24);

   logic signed [63:0] acc_sum;
   assign acc_sum = acc_ff + term_ff;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF)       return 32'sh7FFF_FFFF;
      else if (v < -64'sh8000_0000) return 32'sh8000_0000;
      else                          return v[31:0];
   endfunction

   // rotor mix
   logic [1:0] rj;
   assign rj = cnt_ff[1:0];

   // square root step
   logic [64:0] trial;
   logic        take;
   logic [63:0] res_next;
   assign trial    = {1'b0, res_ff} + {1'b0, bit_ff};
   assign take     = {1'b0, x_ff} >= trial;
   assign res_next = take ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) integ_ff[i] <= '0;
         cnt_ff   <= '0;
         t_ff     <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         rotor_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_action && enable_ff) begin
                  meas_ff[0] <= req_height;
                  meas_ff[1] <= req_vertical_rate;
                  meas_ff[2] <= req_roll_angle;
                  meas_ff[3] <= req_roll_rate;
                  meas_ff[4] <= req_pitch_angle;
                  meas_ff[5] <= req_pitch_rate;
                  meas_ff[6] <= req_yaw_angle;
                  meas_ff[7] <= req_yaw_rate;
                  cnt_ff   <= '0;
                  t_ff     <= '0;
                  row_ff   <= '0;
                  col_ff   <= '0;
                  rotor_ff <= '0;
                  acc_ff   <= '0;
               end
            end
            ST_INTEG: begin
               if (!cnt_ff[0]) begin
                  iprod_ff <= iprod;
               end else if (isum > 50'sh7FFF_FFFF_FFFF) begin
                  integ_ff[ii] <= 48'sh7FFF_FFFF_FFFF;
               end else if (isum < -50'sh8000_0000_0000) begin
                  integ_ff[ii] <= 48'sh8000_0000_0000;
               end else begin
                  integ_ff[ii] <= isum[47:0];
               end
               cnt_ff <= cnt_ff + 5'd1;
            end
            ST_LOAD: begin
               ma_ff   <= coef[47] ? 48'(-coef) : coef;
               mb_ff   <= opb[47] ? 48'(-opb) : opb;
               neg_ff  <= coef[47] ^ opb[47];
               wide_ff <= (t_ff < 6'(GAIN_WORDS)) && (col_ff >= 4'd8);
               prod_ff <= '0;
               cnt_ff  <= '0;
            end
            ST_MUL: begin
               if (cnt_ff[4:2] == 3'd0) begin
                  pp_ff  <= ahalf * bhalf;
                  psh_ff <= 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
               end
               if (cnt_ff != 5'd0) prod_ff <= prod_ff + pp_sh;
               cnt_ff <= cnt_ff + 5'd1;
            end
            ST_SCALE: term_ff <= sshift[63:0];
            ST_ACCUM: begin
               if (t_ff < 6'(GAIN_WORDS)) begin
                  if (col_ff == 4'(STATE_COUNT - 1)) begin
                     act_ff[row_ff] <= sat32(acc_sum);
                     acc_ff <= '0;
                     col_ff <= '0;
                     row_ff <= row_ff + 2'd1;
                  end else begin
                     acc_ff <= acc_sum;
                     col_ff <= col_ff + 4'd1;
                  end
               end else begin
                  mixt_ff[t_ff[1:0]] <= term_ff;
               end
               t_ff <= t_ff + 6'd1;
            end
            ST_HOVER: mixt_ff[0] <= mixt_ff[0] + 64'(coef >>> 8);
            ST_RINIT: begin
               m_ff   <= mixt_ff[0];
               cnt_ff <= '0;
            end
            ST_RADD: begin
               if (ROTOR_NEG[rotor_ff][rj]) m_ff <= m_ff - mixt_ff[rj + 2'd1];
               else                         m_ff <= m_ff + mixt_ff[rj + 2'd1];
               cnt_ff <= cnt_ff + 5'd1;
            end
            ST_RCLAMP: begin
               if (m_ff <= 64'sd0)                     x_ff <= '0;
               else if (m_ff > 64'sh0000_FFFF_FFFF_FFFF) x_ff <= {48'hFFFF_FFFF_FFFF, 16'd0};
               else                                    x_ff <= {m_ff[47:0], 16'd0};
               res_ff <= '0;
               bit_ff <= 64'h4000_0000_0000_0000;
               cnt_ff <= '0;
            end
            ST_SQRT: begin
               if (take) x_ff <= x_ff - trial[63:0];
               res_ff <= res_next;
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  speed_ff[rotor_ff] <= res_next[31:0];
                  rotor_ff <= rotor_ff + 2'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------- result register ----------------
   logic rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_thrust_command <= act_ff[0];
         rsp_roll_command   <= act_ff[1];
         rsp_pitch_command  <= act_ff[2];
         rsp_yaw_command    <= act_ff[3];
         rsp_rotor_speed_a  <= speed_ff[0];
         rsp_rotor_speed_b  <= speed_ff[1];
         rsp_rotor_speed_c  <= speed_ff[2];
         rsp_rotor_speed_d  <= speed_ff[3];
      end
   end

endmodule
